// ===== rtl/vwbp_pkg.sv =====
// Package for the variable width bit packer: field widths, queue sizing,
// front state type and the queue entry struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vwbp_pkg;

   localparam int VALUE_BITS     = 40;
   localparam int COUNT_REG_BITS = 41;
   localparam int WORD_BITS      = 64;
   localparam int WIDTH_BITS     = 6;
   localparam int OFFSET_BITS    = 6;
   localparam int WORDS_BITS     = 40;
   localparam int COUNT_BITS     = 40;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // largest entry count that still changes the field width
   localparam logic [COUNT_REG_BITS-1:0] COUNT_TOP = COUNT_REG_BITS'(1) << COUNT_BITS;

   typedef enum logic {
      FRONT_RUN,
      FRONT_SEARCH
   } front_state_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  is_last;
      logic [WIDTH_BITS-1:0] width;
   } queue_entry_type;

endpackage

`default_nettype wire

// ===== rtl/vwbp_req_if.sv =====
// Input channel of the bit packer: valid/ready handshake and one value.
// Depends on vwbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface vwbp_req_if;
   import vwbp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/vwbp_rsp_if.sv =====
// Result channel of the bit packer: valid/ready handshake and one packed word
// with its run information. Depends on vwbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface vwbp_rsp_if;
   import vwbp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [WORD_BITS-1:0]  packed_word;
   logic                  last_word;
   logic [WIDTH_BITS-1:0] field_width;
   logic [WORDS_BITS-1:0] word_count;

   modport source (output valid, output packed_word, output last_word,
                   output field_width, output word_count, input ready);
   modport sink   (input valid, input packed_word, input last_word,
                   input field_width, input word_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/vwbp_front.sv =====
// Front end: holds the entry count, searches the field width after a write,
// counts values of the run, masks and tags each value. Depends on vwbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vwbp_front (
   input  logic                                 clock,
   input  logic                                 reset,
   vwbp_req_if.sink                             req,
   input  logic                                 csr_write_en,
   input  logic [vwbp_pkg::COUNT_REG_BITS-1:0]  csr_write_data,
   input  logic                                 push_ready,
   output logic                                 push_valid,
   output vwbp_pkg::queue_entry_type            push_entry
);
   import vwbp_pkg::*;

   front_state_type             state_ff, state_in;
   logic [COUNT_REG_BITS-1:0]   count_ff, count_in;
   logic [WIDTH_BITS-1:0]       width_ff, width_in;
   logic [COUNT_REG_BITS-1:0]   taken_ff, taken_in;

   logic [COUNT_REG_BITS-1:0]   eff_count;
   logic [COUNT_REG_BITS-1:0]   taken_plus;
   logic                        step_more;
   logic                        accept;
   logic                        is_last;
   logic [VALUE_BITS-1:0]       value_mask;

   // zero counts as one, large counts saturate
   always_comb begin
      if (count_ff == '0) begin
         eff_count = COUNT_REG_BITS'(1);
      end else if (count_ff > COUNT_TOP) begin
         eff_count = COUNT_TOP;
      end else begin
         eff_count = count_ff;
      end
   end

   assign step_more = (width_ff < WIDTH_BITS'(COUNT_BITS)) &&
                      (eff_count > (COUNT_REG_BITS'(1) << width_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_RUN: begin
            if (csr_write_en) state_in = FRONT_SEARCH;
         end
         FRONT_SEARCH: begin
            if (csr_write_en)    state_in = FRONT_SEARCH;
            else if (!step_more) state_in = FRONT_RUN;
         end
         default: state_in = FRONT_RUN;
      endcase
   end

   // outputs
   always_comb begin
      req.ready = 1'b0;
      case (state_ff)
         FRONT_RUN:    req.ready = push_ready;
         FRONT_SEARCH: req.ready = 1'b0;
         default:      req.ready = 1'b0;
      endcase
   end

   assign accept     = req.valid && req.ready;
   assign taken_plus = taken_ff + COUNT_REG_BITS'(1);
   assign is_last    = (taken_plus >= eff_count);
   assign value_mask = ~({VALUE_BITS{1'b1}} << width_ff);

   assign push_valid         = accept;
   assign push_entry.value   = req.value & value_mask;
   assign push_entry.is_last = is_last;
   assign push_entry.width   = width_ff;

   always_comb begin
      count_in = count_ff;
      width_in = width_ff;
      taken_in = taken_ff;
      if (csr_write_en) begin
         count_in = csr_write_data;
         width_in = WIDTH_BITS'(1);
         taken_in = '0;
      end else begin
         if (state_ff == FRONT_SEARCH && step_more) width_in = width_ff + WIDTH_BITS'(1);
         if (accept) taken_in = is_last ? '0 : taken_plus;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_RUN;
         count_ff <= COUNT_REG_BITS'(1);
         width_ff <= WIDTH_BITS'(1);
         taken_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         width_ff <= width_in;
         taken_ff <= taken_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/vwbp_queue.sv =====
// Short register queue between front and back end.
// Depends on vwbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vwbp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  vwbp_pkg::queue_entry_type  push_entry,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output vwbp_pkg::queue_entry_type  pop_entry
);
   import vwbp_pkg::*;

   queue_entry_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                   push, pop;

   assign push_ready = (cnt_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push && !pop)      cnt_in = cnt_ff + QCNT_BITS'(1);
      else if (!push && pop) cnt_in = cnt_ff - QCNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

// ===== rtl/vwbp_back.sv =====
// Back end: places each value into the word accumulator, emits full and
// flushed words through an output register. Depends on vwbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vwbp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  vwbp_pkg::queue_entry_type  pop_entry,
   vwbp_rsp_if.source                 rsp
);
   import vwbp_pkg::*;

   logic [WORD_BITS-1:0]   acc_ff, acc_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [WORDS_BITS-1:0]  words_ff, words_in;
   logic                   flush_ff, flush_in;
   logic [WIDTH_BITS-1:0]  flush_width_ff, flush_width_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]   rsp_word_ff, rsp_word_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [WIDTH_BITS-1:0]  rsp_width_ff, rsp_width_in;
   logic [WORDS_BITS-1:0]  rsp_count_ff, rsp_count_in;

   logic                   out_free, take;
   logic [WORD_BITS-1:0]   v64, acc_or, spill;
   logic [OFFSET_BITS:0]   next_sum;
   logic                   crosses;
   logic [OFFSET_BITS-1:0] rem;
   logic [WORDS_BITS-1:0]  words_plus;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign pop_ready = out_free && !flush_ff;
   assign take      = pop_valid && pop_ready;

   assign v64        = {{(WORD_BITS - VALUE_BITS){1'b0}}, pop_entry.value};
   assign acc_or     = acc_ff | (v64 << offset_ff);
   assign next_sum   = {1'b0, offset_ff} + {1'b0, pop_entry.width};
   assign crosses    = next_sum[OFFSET_BITS];
   assign rem        = next_sum[OFFSET_BITS-1:0];
   assign spill      = v64 >> (pop_entry.width - rem);
   assign words_plus = words_ff + WORDS_BITS'(1);

   always_comb begin
      acc_in         = acc_ff;
      offset_in      = offset_ff;
      words_in       = words_ff;
      flush_in       = flush_ff;
      flush_width_in = flush_width_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_word_in    = rsp_word_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_width_in   = rsp_width_ff;
      rsp_count_in   = rsp_count_ff;
      if (csr_write_en) begin
         acc_in    = '0;
         offset_in = '0;
         words_in  = '0;
         flush_in  = 1'b0;
      end else if (flush_ff && out_free) begin
         // second word of a spilling final value
         rsp_valid_in = 1'b1;
         rsp_word_in  = acc_ff;
         rsp_last_in  = 1'b1;
         rsp_width_in = flush_width_ff;
         rsp_count_in = words_plus;
         acc_in       = '0;
         offset_in    = '0;
         words_in     = '0;
         flush_in     = 1'b0;
      end else if (take) begin
         if (crosses) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = acc_or;
            rsp_last_in  = pop_entry.is_last && (rem == '0);
            rsp_width_in = pop_entry.width;
            rsp_count_in = words_plus;
            words_in     = words_plus;
            acc_in       = (rem == '0) ? '0 : spill;
            offset_in    = rem;
            if (pop_entry.is_last) begin
               if (rem != '0) begin
                  flush_in       = 1'b1;
                  flush_width_in = pop_entry.width;
               end else begin
                  words_in = '0;
               end
            end
         end else if (pop_entry.is_last) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = acc_or;
            rsp_last_in  = 1'b1;
            rsp_width_in = pop_entry.width;
            rsp_count_in = words_plus;
            acc_in       = '0;
            offset_in    = '0;
            words_in     = '0;
         end else begin
            acc_in    = acc_or;
            offset_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         offset_ff    <= '0;
         words_ff     <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         offset_ff    <= offset_in;
         words_ff     <= words_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flush_width_ff <= flush_width_in;
      rsp_word_ff    <= rsp_word_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_width_ff   <= rsp_width_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.packed_word = rsp_word_ff;
   assign rsp.last_word   = rsp_last_ff;
   assign rsp.field_width = rsp_width_ff;
   assign rsp.word_count  = rsp_count_ff;

endmodule

`default_nettype wire

// ===== rtl/variable_width_bit_packer.sv =====
// Flow: a value is written into the queue on its input transfer; its word, if any, then
//   passes through the back end output register before it appears on rsp.
// Throughput: one value per cycle while the queue has room and rsp is not stalled; a final
//   value that spills into a second word holds the back end for the flush of that word.
//   After a csr write the width search runs one compare per cycle with req_ch.ready low.
// Reset: synchronous, active high; entry count 1 (width 1), run state cleared.
`timescale 1ns / 1ps
`default_nettype none

module variable_width_bit_packer (
   input  logic                                 clock,
   input  logic                                 reset,
   vwbp_req_if.sink                             req_ch,
   vwbp_rsp_if.source                           rsp_ch,
   input  logic                                 csr_write_en,
   input  logic [vwbp_pkg::COUNT_REG_BITS-1:0]  csr_write_data
);
   import vwbp_pkg::*;

   // front to queue
   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_entry;

   // queue to back
   logic            pop_valid;
   logic            pop_ready;
   queue_entry_type pop_entry;

   // Front: take the transfer, mask the value to the field width, and tag
   // the value that closes the run.
   vwbp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .push_ready     (push_ready),
      .push_valid     (push_valid),
      .push_entry     (push_entry)
   );

   // Queue: decouple the two sides so a stalled output does not stall
   // acceptance right away.
   vwbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Back: shift each value into the accumulator, emit full words, flush
   // the partial word at the end of the run and clear for the next one.
   vwbp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_entry    (pop_entry),
      .rsp          (rsp_ch)
   );

endmodule

`default_nettype wire
